// ----- rtl/ddo_pkg.sv -----
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int POSE_BITS_DEF    = 32;
  localparam int ITER_BITS        = 5;

  // 1/K in Q2.30, fixed start vector of the rotation
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_TAKE_R,
    ST_SUMS,
    ST_DIF_LO,
    ST_DIF_HI,
    ST_DIF_ADD,
    ST_CORDIC,
    ST_NEG,
    ST_X_LO,
    ST_X_HI,
    ST_X_ADD,
    ST_Y_LO,
    ST_Y_HI,
    ST_Y_ADD,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_METRES_PER_COUNT = 1'b0,
    REG_HEADING_GAIN     = 1'b1
  } reg_index_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_turn(input logic [ITER_BITS-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/differential_drive_odometry.sv -----
// differential-drive odometry: absolute wheel counts in, updated pose out
// input channel in_valid/in_ready carries left_count and right_count; each
// request yields exactly one pose (pose_x, pose_y, heading) on the
// out_valid/out_ready channel
// an item is taken only when the block is idle; it then runs a fixed
// sequence on one shared 33x33 multiplier and one shared cordic
// shift/add stage: seven states for wheel travel and heading change,
// CORDIC_STEPS rotation steps, then eight more states for the position
// update and output load; a new item is only taken after the previous
// one has left the done state
// the result sits in an output register; if the receiver stalls, the block
// can accept and process the next item, but holds it in the done state
// until the waiting pose is taken
// rst (synchronous) clears pose, previous counts and both config registers
// config writes (cfg_write, cfg_index, cfg_data) take effect at once and
// must only happen while the block is idle
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int POSE_BITS    = ddo_pkg::POSE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [31:0]        heading
);

  localparam logic [ddo_pkg::ITER_BITS-1:0] LAST_ITER =
    ddo_pkg::ITER_BITS'(CORDIC_STEPS - 1);

  ddo_pkg::state_t state, state_next;

  logic [31:0] metres_per_count;
  logic [31:0] heading_gain;
  logic [31:0] last_left, last_right;
  logic [31:0] position_x, position_y, angle;

  logic signed [31:0] delta_l, delta_r;
  logic signed [47:0] travel_l, travel_r;
  logic signed [48:0] diff;
  logic signed [POSE_BITS-1:0] distance;
  logic [31:0] dtheta;
  logic [31:0] acc;

  logic signed [33:0] cx, cy, cz;
  logic [ddo_pkg::ITER_BITS-1:0] iter;
  logic flip;
  logic signed [32:0] cos_v, sin_v;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic signed [48:0] sum_w, diff_w;
  logic [63:0] dist_ext;
  logic [31:0] diff_hi;
  logic take;
  logic [31:0] turn_in;
  logic signed [33:0] shx, shy, atan_ext;

  assign take     = in_valid && in_ready;
  assign sum_w    = {travel_l[47], travel_l} + {travel_r[47], travel_r};
  assign diff_w   = {travel_r[47], travel_r} - {travel_l[47], travel_l};
  assign dist_ext = 64'(distance);
  assign diff_hi  = {{15{diff[48]}}, diff[48:32]};
  // fold the angle into the right half plane, results negated later
  assign turn_in  = (angle[31] ^ angle[30]) ? (angle ^ 32'h8000_0000) : angle;
  assign shx      = cy >>> iter;
  assign shy      = cx >>> iter;
  assign atan_ext = {2'b00, ddo_pkg::atan_turn(iter)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ddo_pkg::ST_MUL_L;
        end
      end
      ddo_pkg::ST_MUL_L: begin
        mul_a      = {delta_l[31], delta_l};
        mul_b      = {1'b0, metres_per_count};
        state_next = ddo_pkg::ST_MUL_R;
      end
      ddo_pkg::ST_MUL_R: begin
        mul_a      = {delta_r[31], delta_r};
        mul_b      = {1'b0, metres_per_count};
        state_next = ddo_pkg::ST_TAKE_R;
      end
      ddo_pkg::ST_TAKE_R:  state_next = ddo_pkg::ST_SUMS;
      ddo_pkg::ST_SUMS:    state_next = ddo_pkg::ST_DIF_LO;
      ddo_pkg::ST_DIF_LO: begin
        mul_a      = {1'b0, diff[31:0]};
        mul_b      = {1'b0, heading_gain};
        state_next = ddo_pkg::ST_DIF_HI;
      end
      ddo_pkg::ST_DIF_HI: begin
        mul_a      = {1'b0, diff_hi};
        mul_b      = {1'b0, heading_gain};
        state_next = ddo_pkg::ST_DIF_ADD;
      end
      ddo_pkg::ST_DIF_ADD: state_next = ddo_pkg::ST_CORDIC;
      ddo_pkg::ST_CORDIC: begin
        if (iter == LAST_ITER) begin
          state_next = ddo_pkg::ST_NEG;
        end
      end
      ddo_pkg::ST_NEG:     state_next = ddo_pkg::ST_X_LO;
      ddo_pkg::ST_X_LO: begin
        mul_a      = {1'b0, dist_ext[31:0]};
        mul_b      = cos_v;
        state_next = ddo_pkg::ST_X_HI;
      end
      ddo_pkg::ST_X_HI: begin
        mul_a      = {1'b0, dist_ext[63:32]};
        mul_b      = cos_v;
        state_next = ddo_pkg::ST_X_ADD;
      end
      ddo_pkg::ST_X_ADD:   state_next = ddo_pkg::ST_Y_LO;
      ddo_pkg::ST_Y_LO: begin
        mul_a      = {1'b0, dist_ext[31:0]};
        mul_b      = sin_v;
        state_next = ddo_pkg::ST_Y_HI;
      end
      ddo_pkg::ST_Y_HI: begin
        mul_a      = {1'b0, dist_ext[63:32]};
        mul_b      = sin_v;
        state_next = ddo_pkg::ST_Y_ADD;
      end
      ddo_pkg::ST_Y_ADD:   state_next = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default:             state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier, product registered before use
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metres_per_count <= '0;
      heading_gain     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddo_pkg::REG_METRES_PER_COUNT: metres_per_count <= cfg_data;
        ddo_pkg::REG_HEADING_GAIN:     heading_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      position_x <= '0;
      position_y <= '0;
      angle      <= '0;
    end else begin
      unique case (state)
        ddo_pkg::ST_IDLE: begin
          if (take) begin
            delta_l    <= left_count - last_left;
            delta_r    <= right_count - last_right;
            last_left  <= left_count;
            last_right <= right_count;
            cx         <= ddo_pkg::CORDIC_START;
            cy         <= '0;
            cz         <= {{2{turn_in[31]}}, turn_in};
            flip       <= angle[31] ^ angle[30];
            iter       <= '0;
          end
        end
        ddo_pkg::ST_MUL_R:   travel_l <= prod[63:16];
        ddo_pkg::ST_TAKE_R:  travel_r <= prod[63:16];
        ddo_pkg::ST_SUMS: begin
          diff     <= diff_w;
          distance <= sum_w[POSE_BITS:1];
        end
        ddo_pkg::ST_DIF_HI:  dtheta <= prod[63:32];
        ddo_pkg::ST_DIF_ADD: dtheta <= dtheta + prod[31:0];
        ddo_pkg::ST_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - shx;
            cy <= cy + shy;
            cz <= cz - atan_ext;
          end else begin
            cx <= cx + shx;
            cy <= cy - shy;
            cz <= cz + atan_ext;
          end
          iter <= iter + 1'b1;
        end
        ddo_pkg::ST_NEG: begin
          cos_v <= flip ? 33'(-cx) : cx[32:0];
          sin_v <= flip ? 33'(-cy) : cy[32:0];
        end
        ddo_pkg::ST_X_HI:    acc <= prod[61:30];
        ddo_pkg::ST_X_ADD:   position_x <= position_x + acc + {prod[29:0], 2'b00};
        ddo_pkg::ST_Y_HI:    acc <= prod[61:30];
        ddo_pkg::ST_Y_ADD: begin
          position_y <= position_y + acc + {prod[29:0], 2'b00};
          angle      <= angle + dtheta;
        end
        default: ;
      endcase
    end
  end

  // output register, loaded once the previous pose is gone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ddo_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      pose_x    <= position_x;
      pose_y    <= position_y;
      heading   <= angle;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/ddo_checker.sv -----
module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pose_x,
  input logic [31:0] pose_y,
  input logic [31:0] heading
);

  // a waiting pose holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(pose_y)
      && $stable(heading))
    else $error("pose changed while stalled");

  // the block is busy, not ready, right after a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("ready too soon after request");

  // a new pose only appears while the block is busy
  a_new_pose: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("pose appeared from idle");

  // no pose right after reset without a request
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pose valid after reset");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pose_x    (pose_x),
  .pose_y    (pose_y),
  .heading   (heading)
);

// ----- sim/differential_drive_odometry_tb.sv -----
`timescale 1ns / 100ps

module differential_drive_odometry_tb;

  localparam int STEPS = ddo_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hd;
  } pose_t;

  class pose_scoreboard;
    logic [31:0] metres_per_count;
    logic [31:0] heading_gain;
    logic [31:0] prev_left;
    logic [31:0] prev_right;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] ang;
    pose_t expected_poses[$];
    int mismatches;
    int poses_checked;

    function void clear();
      metres_per_count = '0;
      heading_gain = '0;
      prev_left = '0;
      prev_right = '0;
      pos_x = '0;
      pos_y = '0;
      ang = '0;
      expected_poses.delete();
      mismatches = 0;
      poses_checked = 0;
    endfunction

    function void set_reg(ddo_pkg::reg_index_t idx, logic [31:0] val);
      if (idx == ddo_pkg::REG_METRES_PER_COUNT) metres_per_count = val;
      else heading_gain = val;
    endfunction

    function logic [31:0] atan_of(int i);
      logic [31:0] t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};
      return t[i];
    endfunction

    // rotation-mode cordic, cos and sin in q2.30
    function void rotate(input logic [31:0] a, output longint c, output longint s);
      longint cx, cy, cz, dx, dy;
      logic [31:0] sum;
      logic flip;
      sum = a + 32'h4000_0000;
      flip = sum[31];
      if (flip) a = a - 32'h8000_0000;
      cx = 652032874;
      cy = 0;
      cz = longint'(signed'(a));
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= longint'(atan_of(i));
        end else begin
          cx += dx; cy -= dy; cz += longint'(atan_of(i));
        end
      end
      if (flip) begin
        cx = -cx; cy = -cy;
      end
      c = cx;
      s = cy;
    endfunction

    function void note_request(logic [31:0] lc, logic [31:0] rc);
      logic [31:0] dl32, dr32, dtheta;
      longint dl, dr, wl, wr, step, c, s, px, py;
      logic [63:0] diff, hprod;
      pose_t p;
      dl32 = lc - prev_left;
      dr32 = rc - prev_right;
      dl = longint'(signed'(dl32));
      dr = longint'(signed'(dr32));
      wl = (dl * longint'({32'b0, metres_per_count})) >>> 16;
      wr = (dr * longint'({32'b0, metres_per_count})) >>> 16;
      step = (wl + wr) >>> 1;
      step = longint'(signed'(step[31:0]));
      diff = wr - wl;
      hprod = diff * {32'b0, heading_gain};
      dtheta = hprod[63:32];
      rotate(ang, c, s);
      px = step * c;
      py = step * s;
      pos_x += px[61:30];
      pos_y += py[61:30];
      ang += dtheta;
      prev_left = lc;
      prev_right = rc;
      p.x = pos_x;
      p.y = pos_y;
      p.hd = ang;
      expected_poses.push_back(p);
    endfunction

    function void check_pose(logic [31:0] x, logic [31:0] y, logic [31:0] hd);
      pose_t p;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose x=%h y=%h heading=%h", x, y, hd);
        return;
      end
      p = expected_poses.pop_front();
      poses_checked++;
      if (x !== p.x || y !== p.y || hd !== p.hd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose mismatch: expected x=%h y=%h heading=%h, got x=%h y=%h heading=%h",
                   p.x, p.y, p.hd, x, y, hd);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] left_count = '0;
  logic signed [31:0] right_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0] heading;

  pose_scoreboard odo_sb = new();
  logic [31:0] last_l = '0, last_r = '0;
  bit no_gaps = 0;
  int requests_sent = 0;
  int idle_cycles = 0;

  differential_drive_odometry dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_count(left_count), .right_count(right_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .pose_x(pose_x), .pose_y(pose_y), .heading(heading)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) odo_sb.note_request(left_count, right_count);
    if (!rst && out_valid && out_ready) odo_sb.check_pose(pose_x, pose_y, heading);
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_counts(logic [31:0] lc, logic [31:0] rc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    left_count <= lc;
    right_count <= rc;
    last_l = lc;
    last_r = rc;
    requests_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (odo_sb.expected_poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(ddo_pkg::reg_index_t idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    odo_sb.set_reg(idx, val);
  endtask

  // mostly small wheel motion, sometimes arbitrary jumps across the wrap
  task automatic send_motion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      send_counts(last_l + $urandom_range(0, 4000) - 2000, last_r + $urandom_range(0, 4000) - 2000);
    else if (r < 85)
      send_counts(last_l + $urandom_range(0, 400), last_r + $urandom_range(0, 400));
    else
      send_counts($urandom, $urandom);
  endtask

  initial begin
    odo_sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // registers still at reset: pose must not move
    send_counts(32'h1234_5678, 32'h8765_4321);
    send_counts('0, '0);
    drain();

    write_reg(ddo_pkg::REG_METRES_PER_COUNT, 32'hFFFF_FFFF);
    write_reg(ddo_pkg::REG_HEADING_GAIN, 32'hFFFF_FFFF);
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_counts(32'hFFFF_FFFF, 32'h0000_0001);
    send_counts(32'h0000_0001, 32'hFFFF_FFFF);
    send_counts(32'h0000_0001, 32'hFFFF_FFFF);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_reg(ddo_pkg::REG_METRES_PER_COUNT, 32'h0100_0000);
    write_reg(ddo_pkg::REG_HEADING_GAIN, 32'h4000_0000);
    // turn on the spot in small steps, then encoder wrap
    repeat (10) send_counts(last_l - 32'd3000, last_r + 32'd3000);
    send_counts(32'h7FFF_FF00, 32'h7FFF_FF00);
    send_counts(32'h8000_0010, 32'h8000_0020);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(ddo_pkg::REG_METRES_PER_COUNT, 32'h0001_0000);
                 write_reg(ddo_pkg::REG_HEADING_GAIN, 32'h0800_0000); end
        1: begin write_reg(ddo_pkg::REG_METRES_PER_COUNT, '0);
                 write_reg(ddo_pkg::REG_HEADING_GAIN, $urandom); end
        2: begin write_reg(ddo_pkg::REG_METRES_PER_COUNT, 32'hFFFF_FFFF);
                 write_reg(ddo_pkg::REG_HEADING_GAIN, '0); end
        default: begin write_reg(ddo_pkg::REG_METRES_PER_COUNT, $urandom);
                 write_reg(ddo_pkg::REG_HEADING_GAIN, $urandom); end
      endcase
      no_gaps = (ph == 3);
      for (int k = 0; k < 205; k++) begin
        if (ph == 4 && k == 100) begin
          // hold off until every pose is back
          in_valid <= 0;
          @(posedge clk);
          while (odo_sb.expected_poses.size() != 0) @(posedge clk);
        end
        send_motion();
      end
      no_gaps = 0;
      drain();
    end

    $display("sent %0d count requests over several register settings, %0d poses checked",
             requests_sent, odo_sb.poses_checked);
    if (odo_sb.mismatches == 0 && odo_sb.expected_poses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d poses missing", odo_sb.mismatches,
               odo_sb.expected_poses.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- differential_drive_odometry.f -----
rtl/ddo_pkg.sv
rtl/differential_drive_odometry.sv
rtl/ddo_checker.sv
sim/differential_drive_odometry_tb.sv
